// ===== rtl/core/sactm_pkg.sv =====
// ----------------------------------------------------------------------------
// Cache timing model package
// Shared constants, register indexes and types of the cache timing model.
// ----------------------------------------------------------------------------
package sactm_pkg;

  // Address split: byte offset, set index and tag.
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned NUM_SETS   = 64;
  localparam int unsigned LINE_BYTES = 16;
  localparam int unsigned OFFSET_W   = $clog2(LINE_BYTES);
  localparam int unsigned SET_W      = $clog2(NUM_SETS);
  localparam int unsigned TAG_W      = ADDR_W - OFFSET_W - SET_W;

  // Field widths of the request and result.
  localparam int unsigned LAT_CFG_W   = 8;
  localparam int unsigned LAT_W       = 10;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned DIRTY_OUT_W = 9;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CACHE_ENABLE  = 2'd0,
    REG_HIT_LATENCY   = 2'd1,
    REG_READ_LATENCY  = 2'd2,
    REG_WRITE_LATENCY = 2'd3
  } cfg_reg_e;

  // Register reset values.
  localparam logic                 RST_CACHE_ENABLE  = 1'b1;
  localparam logic [LAT_CFG_W-1:0] RST_HIT_LATENCY   = 8'd1;
  localparam logic [LAT_CFG_W-1:0] RST_READ_LATENCY  = 8'd100;
  localparam logic [LAT_CFG_W-1:0] RST_WRITE_LATENCY = 8'd100;

  // Access kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  // One way of the tag store as held in the tag RAM.
  typedef struct packed {
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } line_t;

endpackage

// ===== rtl/core/sactm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sactm_ram #(
  parameter int unsigned WIDTH = 92,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a read at the written address returns the old word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/set_assoc_cache_timing_model_top.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache timing model
// Tag store of a write-back, write-allocate cache with round-robin
// replacement, returning hit, writeback, access latency and statistics.
// ----------------------------------------------------------------------------
// The request is registered into the lookup stage and its outcome into the
// result registers, which drive the result strobe and the result.
// Throughput: one request per cycle; busy stays low, since the tag RAM read
// in the accept cycle and the single lookup stage behind it never stall.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset clears the valid bits, counters and pipeline and loads the register
// defaults; the tag RAM is not cleared, as invalid ways are never looked at
// and a set with no valid way reads its victim pointer as zero.
module set_assoc_cache_timing_model_top #(
  parameter int unsigned NUM_WAYS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind_i,
  input  logic [sactm_pkg::ADDR_W-1:0]        address_i,
  // Configuration port
  input  logic                                cfg_we_i,
  input  logic [sactm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sactm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Result channel
  output logic                                result_valid_o,
  output logic                                hit_o,
  output logic                                writeback_o,
  output logic [sactm_pkg::LAT_W-1:0]         latency_o,
  output logic [sactm_pkg::CNT_W-1:0]         read_total_o,
  output logic [sactm_pkg::CNT_W-1:0]         write_total_o,
  output logic [sactm_pkg::CNT_W-1:0]         read_miss_total_o,
  output logic [sactm_pkg::CNT_W-1:0]         write_miss_total_o,
  output logic [sactm_pkg::CNT_W-1:0]         writeback_total_o,
  output logic [sactm_pkg::DIRTY_OUT_W-1:0]   dirty_line_count_o
);

  localparam int unsigned WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned LINES_W = NUM_WAYS * $bits(sactm_pkg::line_t);
  localparam int unsigned ROW_W   = LINES_W + WAY_W;
  localparam int unsigned DCNT_W  = $clog2(sactm_pkg::NUM_SETS * NUM_WAYS + 1);
  localparam int unsigned SET_W   = sactm_pkg::SET_W;
  localparam int unsigned TAG_W   = sactm_pkg::TAG_W;
  localparam int unsigned OFS_W   = sactm_pkg::OFFSET_W;
  localparam int unsigned LAT_W   = sactm_pkg::LAT_W;
  localparam int unsigned CNT_W   = sactm_pkg::CNT_W;
  localparam int unsigned DOUT_W  = sactm_pkg::DIRTY_OUT_W;

  // Configuration registers.
  logic                               cache_enable_q;
  logic [sactm_pkg::LAT_CFG_W-1:0]    hit_latency_q;
  logic [sactm_pkg::LAT_CFG_W-1:0]    read_latency_q;
  logic [sactm_pkg::LAT_CFG_W-1:0]    write_latency_q;

  // Lookup stage registers.
  logic                               s1_valid_q;
  logic                               s1_kind_q;
  logic [sactm_pkg::ADDR_W-1:0]       s1_addr_q;
  logic                               fwd_q, fwd_d;
  logic [ROW_W-1:0]                   fwd_row_q;

  // Per-set valid bits held in flops.
  logic [NUM_WAYS-1:0]                valid_q [sactm_pkg::NUM_SETS];

  // Counters.
  logic [CNT_W-1:0]                   read_cnt_q, write_cnt_q;
  logic [CNT_W-1:0]                   read_miss_cnt_q, write_miss_cnt_q;
  logic [CNT_W-1:0]                   wb_cnt_q;
  logic [DCNT_W-1:0]                  dirty_cnt_q, dirty_cnt_d;

  // Result registers.
  logic                               res_valid_q;
  logic                               hit_q, hit_d;
  logic                               wb_q, wb_d;
  logic [LAT_W-1:0]                   lat_q, lat_d;

  // Tag RAM ports.
  logic                               accept;
  logic [SET_W-1:0]                   acc_set;
  logic [ROW_W-1:0]                   ram_rdata;
  logic [ROW_W-1:0]                   ram_wdata;
  logic                               row_we;

  // Lookup stage signals.
  logic [SET_W-1:0]                   s1_set;
  logic [TAG_W-1:0]                   s1_tag;
  logic                               s1_store;
  logic [ROW_W-1:0]                   row_rd;
  logic [WAY_W-1:0]                   ptr_cur;
  sactm_pkg::line_t [NUM_WAYS-1:0]    row_cur;
  sactm_pkg::line_t [NUM_WAYS-1:0]    row_new;
  logic [NUM_WAYS-1:0]                set_valid;
  logic [NUM_WAYS-1:0]                valid_new;
  logic [WAY_W-1:0]                   victim;
  logic [WAY_W-1:0]                   ptr_new;
  logic [NUM_WAYS-1:0]                hit_vec;
  logic [WAY_W-1:0]                   hit_way;
  logic                               any_hit;
  logic                               victim_dirty;
  logic                               dirty_inc, dirty_dec;
  logic [DCNT_W+DOUT_W-1:0]           dirty_ext;

  assign accept  = start && !busy;
  assign busy    = 1'b0;
  assign acc_set = address_i[OFS_W +: SET_W];

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_enable_q  <= sactm_pkg::RST_CACHE_ENABLE;
      hit_latency_q   <= sactm_pkg::RST_HIT_LATENCY;
      read_latency_q  <= sactm_pkg::RST_READ_LATENCY;
      write_latency_q <= sactm_pkg::RST_WRITE_LATENCY;
    end else if (cfg_we_i) begin
      unique case (sactm_pkg::cfg_reg_e'(cfg_index_i))
        sactm_pkg::REG_CACHE_ENABLE:  cache_enable_q  <= cfg_wdata_i[0];
        sactm_pkg::REG_HIT_LATENCY:   hit_latency_q   <= cfg_wdata_i;
        sactm_pkg::REG_READ_LATENCY:  read_latency_q  <= cfg_wdata_i;
        sactm_pkg::REG_WRITE_LATENCY: write_latency_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Tag RAM: one row of dirty bits, tags and the victim pointer per set,
  // read in the accept cycle.
  sactm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (sactm_pkg::NUM_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (s1_set),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (acc_set),
    .rdata_o (ram_rdata)
  );

  // The row written by the lookup stage is forwarded when the next request
  // reads the same set in the same cycle.
  assign fwd_d = accept && row_we && (acc_set == s1_set);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      fwd_q      <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= kind_i;
      s1_addr_q <= address_i;
      fwd_row_q <= ram_wdata;
    end
  end

  // Lookup: compare all ways, pick the victim and build the updated row.
  // A set without any valid way takes way zero as its victim, whatever its stored pointer holds.
  assign s1_set    = s1_addr_q[OFS_W +: SET_W];
  assign s1_tag    = s1_addr_q[OFS_W + SET_W +: TAG_W];
  assign s1_store  = (s1_kind_q == sactm_pkg::KIND_STORE);
  assign row_rd    = fwd_q ? fwd_row_q : ram_rdata;
  assign row_cur   = row_rd[LINES_W-1:0];
  assign ptr_cur   = row_rd[ROW_W-1 -: WAY_W];
  assign set_valid = valid_q[s1_set];
  assign victim    = (set_valid == '0) ? '0 : ptr_cur;
  assign row_we    = s1_valid_q && cache_enable_q;
  assign ram_wdata = {ptr_new, row_new};

  always_comb begin
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = set_valid[w] && (row_cur[w].tag == s1_tag);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
  end

  assign any_hit      = |hit_vec;
  assign victim_dirty = set_valid[victim] && row_cur[victim].dirty;

  always_comb begin
    row_new   = row_cur;
    valid_new = set_valid;
    ptr_new   = victim;
    dirty_inc = 1'b0;
    dirty_dec = 1'b0;
    if (any_hit) begin
      // A store to a clean line makes it dirty.
      if (s1_store && !row_cur[hit_way].dirty) begin
        row_new[hit_way].dirty = 1'b1;
        dirty_inc              = 1'b1;
      end
    end else begin
      // Refill the round-robin victim.
      row_new[victim].dirty = s1_store;
      row_new[victim].tag   = s1_tag;
      valid_new[victim]     = 1'b1;
      dirty_inc             = s1_store;
      dirty_dec             = victim_dirty;
      ptr_new = (victim == WAY_W'(NUM_WAYS - 1)) ? '0 : victim + WAY_W'(1);
    end
  end

  assign dirty_cnt_d = dirty_cnt_q + DCNT_W'(dirty_inc) - DCNT_W'(dirty_dec);

  // Result of this request.
  always_comb begin
    hit_d = 1'b0;
    wb_d  = 1'b0;
    if (!cache_enable_q) begin
      lat_d = s1_store ? LAT_W'(write_latency_q) : LAT_W'(read_latency_q);
    end else begin
      hit_d = any_hit;
      wb_d  = !any_hit && victim_dirty;
      lat_d = LAT_W'(hit_latency_q)
            + (any_hit ? '0 : LAT_W'(read_latency_q))
            + (wb_d ? LAT_W'(write_latency_q) : '0);
    end
  end

  // Per-set valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < sactm_pkg::NUM_SETS; s++) begin
        valid_q[s] <= '0;
      end
    end else if (row_we) begin
      valid_q[s1_set] <= valid_new;
    end
  end

  // Statistics counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_cnt_q       <= '0;
      write_cnt_q      <= '0;
      read_miss_cnt_q  <= '0;
      write_miss_cnt_q <= '0;
      wb_cnt_q         <= '0;
      dirty_cnt_q      <= '0;
    end else if (row_we) begin
      if (s1_store) begin
        write_cnt_q <= write_cnt_q + CNT_W'(1);
        if (!any_hit) begin
          write_miss_cnt_q <= write_miss_cnt_q + CNT_W'(1);
        end
      end else begin
        read_cnt_q <= read_cnt_q + CNT_W'(1);
        if (!any_hit) begin
          read_miss_cnt_q <= read_miss_cnt_q + CNT_W'(1);
        end
      end
      if (wb_d) begin
        wb_cnt_q <= wb_cnt_q + CNT_W'(1);
      end
      dirty_cnt_q <= dirty_cnt_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      hit_q <= hit_d;
      wb_q  <= wb_d;
      lat_q <= lat_d;
    end
  end

  assign dirty_ext = {{DOUT_W{1'b0}}, dirty_cnt_q};

  assign result_valid_o     = res_valid_q;
  assign hit_o              = hit_q;
  assign writeback_o        = wb_q;
  assign latency_o          = lat_q;
  assign read_total_o       = read_cnt_q;
  assign write_total_o      = write_cnt_q;
  assign read_miss_total_o  = read_miss_cnt_q;
  assign write_miss_total_o = write_miss_cnt_q;
  assign writeback_total_o  = wb_cnt_q;
  assign dirty_line_count_o = dirty_ext[DOUT_W-1:0];

endmodule

// ===== rtl/core/sactm_checker.sv =====
// ----------------------------------------------------------------------------
// Cache timing model checker
// Port-level assertions on the cache timing model, bound to the top level.
// ----------------------------------------------------------------------------
module sactm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               result_valid_o,
  input logic                               hit_o,
  input logic                               writeback_o,
  input logic [sactm_pkg::CNT_W-1:0]        read_total_o,
  input logic [sactm_pkg::CNT_W-1:0]        read_miss_total_o,
  input logic [sactm_pkg::CNT_W-1:0]        write_miss_total_o,
  input logic [sactm_pkg::CNT_W-1:0]        writeback_total_o,
  input logic [sactm_pkg::DIRTY_OUT_W-1:0]  dirty_line_count_o
);

  // Every accepted request raises the result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("accepted request produced no result");

  // A line that hits is never evicted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> !writeback_o)
    else $error("writeback reported on a hit");

  // A hit leaves the miss counters untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |->
      (read_miss_total_o == $past(read_miss_total_o)) &&
      (write_miss_total_o == $past(write_miss_total_o)))
    else $error("miss counter moved on a hit");

  // A writeback shows up in the writeback total of the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && writeback_o) |->
      (writeback_total_o != $past(writeback_total_o)))
    else $error("writeback not counted");

  // Statistics only move together with a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> ($stable(read_total_o) && $stable(dirty_line_count_o)))
    else $error("statistics changed without a result");

endmodule

bind set_assoc_cache_timing_model_top sactm_checker u_sactm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .result_valid_o     (result_valid_o),
  .hit_o              (hit_o),
  .writeback_o        (writeback_o),
  .read_total_o       (read_total_o),
  .read_miss_total_o  (read_miss_total_o),
  .write_miss_total_o (write_miss_total_o),
  .writeback_total_o  (writeback_total_o),
  .dirty_line_count_o (dirty_line_count_o)
);
